### rtl/sgdmf_pkg.sv
// shared constants, state encoding and saturation helpers for the
// matrix factorization engine; no dependencies
`default_nettype none
package sgdmf_pkg;

	localparam int NUM_USERS  = 1024;
	localparam int NUM_MOVIES = 4096;
	localparam int MAX_RANK   = 16;
	localparam int USER_W     = 10;
	localparam int MOVIE_W    = 12;
	localparam int RANK_W     = 4;
	localparam int USER_AW    = USER_W + RANK_W;
	localparam int MOVIE_AW   = MOVIE_W + RANK_W;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_TRAIN   = 2'd1;
	localparam logic [1:0] REQ_EVAL    = 2'd2;
	localparam logic [1:0] REQ_PREDICT = 2'd3;

	localparam logic [1:0] CFG_RANK = 2'd0;
	localparam logic [1:0] CFG_ETA  = 2'd1;
	localparam logic [1:0] CFG_LAM  = 2'd2;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_DRD  = 12'b000000000010,
		ST_DMUL = 12'b000000000100,
		ST_DACC = 12'b000000001000,
		ST_RES  = 12'b000000010000,
		ST_URD  = 12'b000000100000,
		ST_UM1  = 12'b000001000000,
		ST_UM2  = 12'b000010000000,
		ST_UM3  = 12'b000100000000,
		ST_UM4  = 12'b001000000000,
		ST_UM5  = 12'b010000000000,
		ST_UM6  = 12'b100000000000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) r = 32'sh7fffffff;
		else if (v < -56'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [30:0] sat_mag(input logic signed [55:0] v);
		logic signed [55:0] m;
		logic [30:0] r;
		m = (v < 0) ? -v : v;
		if (m > 56'sd2147483647) r = 31'h7fffffff;
		else r = m[30:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/sgdmf_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
`default_nettype none
module sgdmf_ram #(
	parameter int AW = 14,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/sgdmf_mul.sv
// shared signed multiplier with registered product
// uses sgdmf_pkg for operand widths
`default_nettype none
module sgdmf_mul import sgdmf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic      signed [PROD_W-1:0] prod
);
	always_ff @(posedge clk) begin
		prod <= a * b;
	end
endmodule
`default_nettype wire

### rtl/sgd_matrix_factorization.sv
// a load request goes from idle straight to the result state; evaluate, predict
// and train requests step through ST_DRD, ST_DMUL and ST_DACC per rank position
// for the dot product, then reach the result state; train then runs the updates,
// per rank position ST_URD and two passes of ST_UM1 to ST_UM6 (user, then movie)
// one request at a time; the steps share the single multiplier and one ram read
// port per table; a waiting result holds the engine in its result state
// reset clears control state and config to rank 16, eta 655, lambda 655;
// factor tables are undefined until loaded
`default_nettype none
module sgd_matrix_factorization import sgdmf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [USER_W-1:0]  user_index,
	input  wire logic [MOVIE_W-1:0] movie_index,
	input  wire logic [18:0]        rating_mark,
	input  wire logic               table_select,
	input  wire logic [RANK_W-1:0]  rank_index,
	input  wire logic signed [31:0] factor_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      predicted_value,
	output logic [30:0]             abs_error,
	input  wire logic               cfg_write_en,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	state_t state_q;
	logic [4:0]  rank_cfg_q, rank_q, k_q;
	logic [15:0] eta_q, lam_q;
	logic [1:0]  req_q;
	logic [USER_W-1:0]  u_q;
	logic [MOVIE_W-1:0] m_q;
	logic [18:0] mark_q;
	logic side_q;
	logic signed [51:0] acc_q;
	logic signed [31:0] err_q, cu_q, cm_q, nu_q;
	logic signed [PROD_W-1:0] a_q;
	logic signed [64:0] d_q;
	logic signed [31:0] u_rd, m_rd;
	logic signed [PROD_W-1:0] prod;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic in_acc, pos_ok, res_go;
	logic u_we, m_we;
	logic [USER_AW-1:0]  u_waddr;
	logic [MOVIE_AW-1:0] m_waddr;
	logic signed [31:0] wdata, nv;
	logic signed [16:0] e2;
	logic signed [55:0] dot_x, err_x, upd_x;
	logic [4:0] k_next;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign pos_ok   = ({1'b0, rank_index} < 5'(MAX_RANK));
	// twice the learning rate
	assign e2       = {eta_q, 1'b0};
	assign k_next   = k_q + 5'd1;
	assign res_go   = (state_q == ST_RES) && (!out_valid || out_ready);

	assign dot_x = {{4{acc_q[51]}}, acc_q};
	assign err_x = $signed({37'b0, mark_q}) - dot_x;
	assign upd_x = $signed({{24{(side_q ? cm_q[31] : cu_q[31])}}, (side_q ? cm_q : cu_q)})
		+ prod[55:0] + $signed({38'b0, a_q[49:32]});
	assign nv = sat32(upd_x);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DMUL: begin
				mul_a = {u_rd[31], u_rd};
				mul_b = {m_rd[31], m_rd};
			end
			ST_UM1: begin
				mul_a = {err_q[31], err_q};
				mul_b = side_q ? {nu_q[31], nu_q} : {m_rd[31], m_rd};
			end
			ST_UM2: begin
				mul_a = {17'b0, lam_q};
				mul_b = side_q ? {cm_q[31], cm_q} : {cu_q[31], cu_q};
			end
			ST_UM4: begin
				mul_a = {1'b0, d_q[31:0]};
				mul_b = {16'b0, e2};
			end
			ST_UM5: begin
				mul_a = d_q[64:32];
				mul_b = {16'b0, e2};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// table write port: loads in idle, updates at the end of each step
	always_comb begin
		u_we    = 1'b0;
		m_we    = 1'b0;
		u_waddr = {u_q, k_q[RANK_W-1:0]};
		m_waddr = {m_q, k_q[RANK_W-1:0]};
		wdata   = nv;
		if (state_q == ST_IDLE) begin
			u_waddr = {user_index, rank_index};
			m_waddr = {movie_index, rank_index};
			wdata   = factor_value;
			u_we    = in_acc && (req_type == REQ_LOAD) && pos_ok && !table_select;
			m_we    = in_acc && (req_type == REQ_LOAD) && pos_ok && table_select;
		end else if (state_q == ST_UM6) begin
			u_we = !side_q;
			m_we = side_q;
		end
	end

	sgdmf_ram #(.AW(USER_AW), .DW(32)) u_user_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (wdata),
		.raddr ({u_q, k_q[RANK_W-1:0]}),
		.rdata (u_rd)
	);

	sgdmf_ram #(.AW(MOVIE_AW), .DW(32)) u_movie_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (wdata),
		.raddr ({m_q, k_q[RANK_W-1:0]}),
		.rdata (m_rd)
	);

	sgdmf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_cfg_q <= 5'd16;
			eta_q      <= 16'd655;
			lam_q      <= 16'd655;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_RANK: rank_cfg_q <= cfg_data[4:0];
				CFG_ETA:  eta_q      <= cfg_data;
				CFG_LAM:  lam_q      <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			k_q       <= '0;
			side_q    <= 1'b0;
		end else begin
			out_valid <= res_go || (out_valid && !out_ready);
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					k_q     <= '0;
					side_q  <= 1'b0;
					state_q <= (req_type == REQ_LOAD) ? ST_RES : ST_DRD;
				end
				ST_DRD:  state_q <= (k_q == rank_q) ? ST_RES : ST_DMUL;
				ST_DMUL: state_q <= ST_DACC;
				ST_DACC: begin
					k_q     <= k_next;
					state_q <= ST_DRD;
				end
				ST_RES: if (res_go) begin
					k_q <= '0;
					if (req_q == REQ_TRAIN && rank_q != 5'd0) state_q <= ST_URD;
					else state_q <= ST_IDLE;
				end
				ST_URD: state_q <= ST_UM1;
				ST_UM1: state_q <= ST_UM2;
				ST_UM2: state_q <= ST_UM3;
				ST_UM3: state_q <= ST_UM4;
				ST_UM4: state_q <= ST_UM5;
				ST_UM5: state_q <= ST_UM6;
				ST_UM6: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= ST_UM1;
					end else begin
						side_q  <= 1'b0;
						k_q     <= k_next;
						state_q <= (k_next == rank_q) ? ST_IDLE : ST_URD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_type;
			u_q    <= user_index;
			m_q    <= movie_index;
			mark_q <= rating_mark;
			rank_q <= (rank_cfg_q > 5'(MAX_RANK)) ? 5'(MAX_RANK) : rank_cfg_q;
			acc_q  <= '0;
		end
		if (state_q == ST_DACC) acc_q <= acc_q + {{2{prod[PROD_W-1]}}, prod[PROD_W-1:16]};
		if (res_go) begin
			err_q <= sat32(err_x);
			if (req_q == REQ_LOAD) begin
				predicted_value <= '0;
				abs_error       <= '0;
			end else begin
				predicted_value <= sat32(dot_x);
				abs_error       <= (req_q == REQ_PREDICT) ? 31'd0 : sat_mag(err_x);
			end
		end
		if (state_q == ST_UM1 && !side_q) begin
			cu_q <= u_rd;
			cm_q <= m_rd;
		end
		if (state_q == ST_UM2 || state_q == ST_UM5) a_q <= prod;
		if (state_q == ST_UM3) d_q <= a_q[64:0] - prod[64:0];
		if (state_q == ST_UM6 && !side_q) nu_q <= nv;
	end
endmodule
`default_nettype wire

### rtl/sgdmf_checker.sv
// port-level checks for the matrix factorization engine
// bound to sgd_matrix_factorization; uses sgdmf_pkg widths
`default_nettype none
module sgdmf_checker import sgdmf_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [1:0]         req_type,
	input wire logic [USER_W-1:0]  user_index,
	input wire logic [MOVIE_W-1:0] movie_index,
	input wire logic [18:0]        rating_mark,
	input wire logic               table_select,
	input wire logic [RANK_W-1:0]  rank_index,
	input wire logic signed [31:0] factor_value,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] predicted_value,
	input wire logic [30:0]        abs_error,
	input wire logic               cfg_write_en,
	input wire logic [1:0]         cfg_index,
	input wire logic [15:0]        cfg_data
);
	// one request in flight: ready drops right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after request");

	// a result never shows up the cycle after its request
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(predicted_value) && $stable(abs_error))
		else $error("result changed while stalled");
endmodule

bind sgd_matrix_factorization sgdmf_checker u_sgdmf_checker (.*);
`default_nettype wire
